// File: hdl/msit_pkg.sv
// ----------------------------------------------------------------------------
// msit_pkg
// Shared codes and controller/datapath interface types for the interval timer.
// ----------------------------------------------------------------------------
`default_nettype none

package msit_pkg;

    // request actions
    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_CANCEL  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_TICK    = 2'd3
    } action_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_ADD      = 3'd0,
        KIND_CANCEL   = 3'd1,
        KIND_RELEASE  = 3'd2,
        KIND_EXPIRE   = 3'd3,
        KIND_TICK_END = 3'd4
    } kind_t;

    // result status codes
    typedef enum logic [2:0] {
        RES_OK            = 3'd0,
        RES_NO_SPACE      = 3'd1,
        RES_INVALID_ID    = 3'd2,
        RES_ALREADY_ENDED = 3'd3,
        RES_STILL_BUSY    = 3'd4
    } res_t;

    // stored slot state; code 3 never written, reads as not busy
    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_CANCEL = 2'd2;

    // slot table write flavors
    typedef enum logic [1:0] {
        WR_ADD    = 2'd0,
        WR_CANCEL = 2'd1,
        WR_TICK   = 2'd2
    } wr_mode_t;

    typedef struct packed {
        logic     accept;
        logic     rd;
        logic     idx_inc;
        logic     wr;
        wr_mode_t wr_mode;
        logic     used_clr;
        logic     push;
        kind_t    push_kind;
        res_t     push_status;
        logic     push_last;
        logic     push_slot_zero;
    } dp_cmd_t;

    typedef struct packed {
        action_t act;
        logic    id_valid;
        logic    used;
        logic    idx_last;
        logic    busy;
        logic    repeat_flag;
        logic    expire;
        logic    out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/multi_slot_interval_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_interval_timer
// Timer slot table with add, cancel, release and tick requests.
// ----------------------------------------------------------------------------
// Sequence: add scans from slot 0 for the lowest free slot, all slots when full;
//   cancel or release read the slot unless the id is out of range or free; tick
//   reads every used slot. Each result shows the cycle after its push, via the output register.
// Throughput: one request at a time; a result waiting in the output register
//   stalls the sequencer. A new request is taken as soon as it is idle.
// Reset: asynchronous, active low; clears used bits and sequencer, no clearing pass.
`default_nettype none

module multi_slot_interval_timer
    import msit_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [3:0] job_id, [19:4] period,
                                             // [20] repeat_req, [23:21] zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
    // result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [3:0] slot, [6:4] status, [7] zero
    output logic [2:0]       m_axis_tuser,   // [2:0] kind
    output logic             m_axis_tlast    // final result of the request
);

    dp_cmd_t    cmd;
    dp_sts_t    sts;
    logic [3:0] res_slot;
    logic [2:0] res_status;

    // sequencer: decides what each cycle does from datapath status
    msit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // slot table, used bits, scan index and result register
    msit_dp #(
        .SLOTS       (SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_action  (s_axis_tuser),
        .in_job_id  (s_axis_tdata[3:0]),
        .in_period  (s_axis_tdata[19:4]),
        .in_repeat  (s_axis_tdata[20]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_slot   (res_slot),
        .out_status (res_status),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, res_status, res_slot};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // one request at a time: ready drops right after a request is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous one in progress");

    // expiry results are never last and always report ok
    a_expire_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_EXPIRE) |->
            (!m_axis_tlast && m_axis_tdata[6:4] == RES_OK))
        else $error("malformed expiry result");

    // a successful add hands out a slot inside the table
    a_add_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_ADD && m_axis_tdata[6:4] == RES_OK) |->
            (int'(m_axis_tdata[3:0]) < SLOTS || SLOTS > 16))
        else $error("add returned slot outside table");

    // answers and tick end close their request
    a_closing: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_EXPIRE) |-> m_axis_tlast)
        else $error("closing result without last");

endmodule

`default_nettype wire

// File: hdl/msit_dp.sv
// ----------------------------------------------------------------------------
// msit_dp
// Slot table, scan index, request latch and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msit_dp
    import msit_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    output dp_sts_t          sts,
    input  wire logic [1:0]  in_action,
    input  wire logic [3:0]  in_job_id,
    input  wire logic [15:0] in_period,
    input  wire logic        in_repeat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       out_kind,
    output logic [3:0]       out_slot,
    output logic [2:0]       out_status,
    output logic             out_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    // request latch
    action_t                act_reg;
    logic                   id_valid_reg;
    logic [COUNT_WIDTH-1:0] per_reg;
    logic                   rep_reg;
    logic [IDX_W-1:0]       idx_reg;

    // slot table
    logic [SLOTS-1:0]       used_reg;
    logic [1:0]             mem_status [SLOTS];
    logic                   mem_repeat [SLOTS];
    logic [COUNT_WIDTH-1:0] mem_period [SLOTS];
    logic [COUNT_WIDTH-1:0] mem_remain [SLOTS];

    logic [1:0]             rd_status_reg;
    logic                   rd_repeat_reg;
    logic [COUNT_WIDTH-1:0] rd_period_reg;
    logic [COUNT_WIDTH-1:0] rd_remain_reg;

    logic [1:0]             wr_status;
    logic                   wr_repeat;
    logic [COUNT_WIDTH-1:0] wr_period;
    logic [COUNT_WIDTH-1:0] wr_remain;

    logic [31:0]            per_wide;
    logic [COUNT_WIDTH-1:0] per_sat;
    logic                   rd_expire;

    // result register
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [3:0] out_slot_reg;
    res_t       out_status_reg;
    logic       out_last_reg;

    assign per_wide = 32'(in_period);
    assign per_sat  = (per_wide > CNT_MAX[31:0]) ? CNT_MAX[COUNT_WIDTH-1:0]
                                                 : per_wide[COUNT_WIDTH-1:0];
    assign rd_expire = (rd_remain_reg <= COUNT_WIDTH'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= ACT_ADD;
            id_valid_reg <= 1'b0;
            idx_reg      <= '0;
            used_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                act_reg      <= action_t'(in_action);
                id_valid_reg <= (int'(in_job_id) < SLOTS);
                if (action_t'(in_action) == ACT_ADD || action_t'(in_action) == ACT_TICK)
                    idx_reg <= '0;
                else
                    idx_reg <= IDX_W'(in_job_id);
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.wr && cmd.wr_mode == WR_ADD)
                used_reg[idx_reg] <= 1'b1;
            else if (cmd.used_clr)
                used_reg[idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            per_reg <= per_sat;
            rep_reg <= in_repeat;
        end
    end

    // write data per flavor
    always_comb
    begin
        wr_status = rd_status_reg;
        wr_repeat = rd_repeat_reg;
        wr_period = rd_period_reg;
        wr_remain = rd_remain_reg;
        unique case (cmd.wr_mode)
            WR_ADD:
            begin
                wr_status = ST_BUSY;
                wr_repeat = rep_reg;
                wr_period = per_reg;
                wr_remain = per_reg;
            end
            WR_CANCEL:
            begin
                wr_status = ST_CANCEL;
            end
            WR_TICK:
            begin
                if (!rd_expire)
                    wr_remain = rd_remain_reg - COUNT_WIDTH'(1);
                else if (rd_repeat_reg)
                    wr_remain = rd_period_reg;
                else
                begin
                    wr_remain = '0;
                    wr_status = ST_DONE;
                end
            end
            default:
            begin
                wr_status = rd_status_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem_status[idx_reg] <= wr_status;
            mem_repeat[idx_reg] <= wr_repeat;
            mem_period[idx_reg] <= wr_period;
            mem_remain[idx_reg] <= wr_remain;
        end
        if (cmd.rd)
        begin
            rd_status_reg <= mem_status[idx_reg];
            rd_repeat_reg <= mem_repeat[idx_reg];
            rd_period_reg <= mem_period[idx_reg];
            rd_remain_reg <= mem_remain[idx_reg];
        end
    end

    // result register: loads on push, drains on ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.push)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_kind_reg   <= cmd.push_kind;
            out_slot_reg   <= cmd.push_slot_zero ? 4'd0 : 4'(idx_reg);
            out_status_reg <= cmd.push_status;
            out_last_reg   <= cmd.push_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_slot   = out_slot_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    always_comb
    begin
        sts.act         = act_reg;
        sts.id_valid    = id_valid_reg;
        sts.used        = used_reg[idx_reg];
        sts.idx_last    = (idx_reg == IDX_W'(SLOTS - 1));
        sts.busy        = (rd_status_reg == ST_BUSY);
        sts.repeat_flag = rd_repeat_reg;
        sts.expire      = rd_expire;
        sts.out_free    = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

// File: hdl/msit_ctrl.sv
// ----------------------------------------------------------------------------
// msit_ctrl
// Sequencer for add scan, cancel/release check and tick walk.
// ----------------------------------------------------------------------------
`default_nettype none

module msit_ctrl
    import msit_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_action,
    output logic            in_ready,
    input  wire dp_sts_t    sts,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHK,
        S_EVAL,
        S_TICK,
        S_TEVAL,
        S_END
    } state_t;

    state_t state_reg;
    state_t state_next;
    kind_t  ans_kind;

    assign in_ready = (state_reg == S_IDLE);
    assign ans_kind = (sts.act == ACT_CANCEL) ? KIND_CANCEL : KIND_RELEASE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (action_t'(in_action))
                        ACT_ADD:  state_next = S_SCAN;
                        ACT_TICK: state_next = S_TICK;
                        default:  state_next = S_CHK;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!sts.used)
                begin
                    if (sts.out_free)
                    begin
                        cmd.wr          = 1'b1;
                        cmd.wr_mode     = WR_ADD;
                        cmd.push        = 1'b1;
                        cmd.push_kind   = KIND_ADD;
                        cmd.push_status = RES_OK;
                        cmd.push_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (sts.idx_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.push           = 1'b1;
                        cmd.push_kind      = KIND_ADD;
                        cmd.push_status    = RES_NO_SPACE;
                        cmd.push_last      = 1'b1;
                        cmd.push_slot_zero = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_CHK:
            begin
                if (!sts.id_valid || !sts.used)
                begin
                    if (sts.out_free)
                    begin
                        cmd.push        = 1'b1;
                        cmd.push_kind   = ans_kind;
                        cmd.push_status = RES_INVALID_ID;
                        cmd.push_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_kind = ans_kind;
                    cmd.push_last = 1'b1;
                    state_next    = S_IDLE;
                    if (sts.act == ACT_CANCEL)
                    begin
                        if (sts.busy)
                        begin
                            cmd.wr          = 1'b1;
                            cmd.wr_mode     = WR_CANCEL;
                            cmd.push_status = RES_OK;
                        end
                        else
                            cmd.push_status = RES_ALREADY_ENDED;
                    end
                    else if (sts.repeat_flag)
                        cmd.push_status = RES_INVALID_ID;
                    else if (sts.busy)
                        cmd.push_status = RES_STILL_BUSY;
                    else
                    begin
                        cmd.used_clr    = 1'b1;
                        cmd.push_status = RES_OK;
                    end
                end
            end
            S_TICK:
            begin
                if (sts.used)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_TEVAL;
                end
                else if (sts.idx_last)
                    state_next = S_END;
                else
                    cmd.idx_inc = 1'b1;
            end
            S_TEVAL:
            begin
                // slot done when not busy, counting down, or expiry pushed
                if (!sts.busy || !sts.expire || sts.out_free)
                begin
                    if (sts.busy)
                    begin
                        cmd.wr      = 1'b1;
                        cmd.wr_mode = WR_TICK;
                    end
                    if (sts.busy && sts.expire)
                    begin
                        cmd.push        = 1'b1;
                        cmd.push_kind   = KIND_EXPIRE;
                        cmd.push_status = RES_OK;
                    end
                    if (sts.idx_last)
                        state_next = S_END;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_TICK;
                    end
                end
            end
            S_END:
            begin
                if (sts.out_free)
                begin
                    cmd.push           = 1'b1;
                    cmd.push_kind      = KIND_TICK_END;
                    cmd.push_status    = RES_OK;
                    cmd.push_last      = 1'b1;
                    cmd.push_slot_zero = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
